// ===== rtl/sbsl_pkg.sv =====
// Shared types, constants and codes of the section-bounded symbol lookup.
package sbsl_pkg;

    localparam int DEF_MAX_SPANS   = 64;
    localparam int DEF_MAX_SYMBOLS = 4096;
    localparam int SECTION_LIMIT   = 64;
    localparam int SPAN_SEC_W      = $clog2(SECTION_LIMIT);
    localparam int ADDR_W          = 64;
    localparam int SEC_W           = 16;
    localparam int NAME_W          = 32;
    localparam int STR_SIZE_W      = 33;
    localparam int KIND_W          = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPAN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]     start;
        logic [ADDR_W-1:0]     length;
        logic [SPAN_SEC_W-1:0] section;
    } sbsl_span_t;

    typedef struct packed {
        logic [ADDR_W-1:0] value;
        logic [ADDR_W-1:0] size;
        logic [SEC_W-1:0]  section;
        logic [NAME_W-1:0] name;
    } sbsl_sym_t;

    typedef struct packed {
        logic              covers;
        logic              closer;
        logic [ADDR_W-1:0] delta;
    } sbsl_cmp_t;

endpackage

// ===== rtl/sbsl_req_if.sv =====
// Request channel carrying one table update or lookup item.
interface sbsl_req_if
    import sbsl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [SEC_W-1:0]  section;
    logic              is_exec;
    logic              is_alloc;
    logic [NAME_W-1:0] name_offset;

    modport source (output valid, kind, address, length, section, is_exec, is_alloc,
                    name_offset, input ready);
    modport sink (input valid, kind, address, length, section, is_exec, is_alloc,
                  name_offset, output ready);
endinterface

// ===== rtl/sbsl_rsp_if.sv =====
// Result channel carrying one lookup result item.
interface sbsl_rsp_if
    import sbsl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              found;
    logic              in_span;
    logic              is_code;
    logic [NAME_W-1:0] symbol_name;
    logic [ADDR_W-1:0] distance;

    modport source (output valid, found, in_span, is_code, symbol_name, distance,
                    input ready);
    modport sink (input valid, found, in_span, is_code, symbol_name, distance,
                  output ready);
endinterface

// ===== rtl/sbsl_ram.sv =====
// Simple dual-port table memory with one write port and a registered read port.
module sbsl_ram
    import sbsl_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_SPANS,
    parameter int WIDTH = $bits(sbsl_span_t)
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/sbsl_cmp_unit.sv =====
// Shared subtract and compare unit used by both the span scan and the symbol scan.
module sbsl_cmp_unit
    import sbsl_pkg::*;
(
    input  logic [ADDR_W-1:0] probe,
    input  logic [ADDR_W-1:0] base,
    input  logic [ADDR_W-1:0] limit,
    input  logic              limit_en,
    input  logic [ADDR_W-1:0] best_dist,
    input  logic              best_valid,
    output sbsl_cmp_t         res
);

    logic [ADDR_W:0] diff;

    assign diff = {1'b0, probe} - {1'b0, base};

    always_comb
    begin
        res.delta  = diff[ADDR_W-1:0];
        res.covers = !diff[ADDR_W] && (!limit_en || (diff[ADDR_W-1:0] < limit));
        res.closer = !best_valid || (diff[ADDR_W-1:0] < best_dist);
    end

endmodule

// ===== rtl/section_bounded_symbol_lookup.sv =====
// Top level: table storage, scan sequencer and result register of the symbol lookup.
//
// Clear, span and symbol items are taken in the idle state and leave ready high, so
// the block can take a new item in the next cycle. A lookup scans the stored spans
// one entry per cycle until one holds the address and, only when one does, then
// scans the stored symbols, through one read port per table and one shared subtract
// and compare unit. ready stays low from the accepted lookup until its result is
// registered; that last step is held for as long as an earlier result still waits
// on the result channel.
// The tables need no clearing pass after reset.
module section_bounded_symbol_lookup
    import sbsl_pkg::*;
#(
    parameter int MAX_SPANS   = DEF_MAX_SPANS,
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [STR_SIZE_W-1:0] cfg_wdata,
    sbsl_req_if.sink              request,
    sbsl_rsp_if.source            result
);

    localparam int SPAN_IDX_W = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int SYM_IDX_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int SPAN_CNT_W = $clog2(MAX_SPANS + 1);
    localparam int SYM_CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int SCAN_W     = (SPAN_CNT_W > SYM_CNT_W) ? SPAN_CNT_W : SYM_CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SPAN = 4'b0010,
        ST_SYM  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [SPAN_CNT_W-1:0]   span_cnt_reg, span_cnt_next;
    logic [SYM_CNT_W-1:0]    sym_cnt_reg, sym_cnt_next;
    logic [SECTION_LIMIT-1:0] exec_reg, exec_next;
    logic [STR_SIZE_W-1:0]   str_size_reg, str_size_next;
    logic [SCAN_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                    pend_reg, pend_next;
    logic                    span_hit_reg, span_hit_next;
    logic                    best_valid_reg, best_valid_next;
    logic                    res_valid_reg, res_valid_next;

    logic [ADDR_W-1:0]       probe_reg, probe_next;
    logic [SPAN_SEC_W-1:0]   sec_reg, sec_next;
    logic                    code_reg, code_next;
    logic [ADDR_W-1:0]       best_dist_reg, best_dist_next;
    logic [NAME_W-1:0]       best_name_reg, best_name_next;
    logic                    res_found_reg, res_found_next;
    logic                    res_in_span_reg, res_in_span_next;
    logic                    res_code_reg, res_code_next;
    logic [NAME_W-1:0]       res_name_reg, res_name_next;
    logic [ADDR_W-1:0]       res_dist_reg, res_dist_next;

    logic                    accept;
    logic                    span_we;
    logic                    sym_we;
    logic                    span_sec_ok;
    sbsl_span_t              span_wr;
    sbsl_span_t              span_rd;
    sbsl_sym_t               sym_wr;
    sbsl_sym_t               sym_rd;
    logic [ADDR_W-1:0]       cmp_base;
    logic [ADDR_W-1:0]       cmp_limit;
    logic                    cmp_limit_en;
    sbsl_cmp_t               cmp;
    logic                    issue_span;
    logic                    issue_sym;
    logic                    sym_cand;
    logic                    name_ok;
    logic                    out_free;

    assign accept      = request.valid && request.ready;
    assign span_sec_ok = request.section < SEC_W'(SECTION_LIMIT);
    assign span_we     = accept && (request.kind == KIND_SPAN) && span_sec_ok &&
                         request.is_alloc && (request.address != '0) &&
                         (request.length != '0) &&
                         (span_cnt_reg < SPAN_CNT_W'(MAX_SPANS));
    assign sym_we      = accept && (request.kind == KIND_SYMBOL) &&
                         (sym_cnt_reg < SYM_CNT_W'(MAX_SYMBOLS));

    always_comb
    begin
        span_wr.start   = request.address;
        span_wr.length  = request.length;
        span_wr.section = request.section[SPAN_SEC_W-1:0];
        sym_wr.value    = request.address;
        sym_wr.size     = request.length;
        sym_wr.section  = request.section;
        sym_wr.name     = request.name_offset;
    end

    sbsl_ram #(
        .DEPTH (MAX_SPANS),
        .WIDTH ($bits(sbsl_span_t))
    ) u_span_ram (
        .clk     (clk),
        .wr_en   (span_we),
        .wr_addr (span_cnt_reg[SPAN_IDX_W-1:0]),
        .wr_data (span_wr),
        .rd_addr (scan_idx_reg[SPAN_IDX_W-1:0]),
        .rd_data (span_rd)
    );

    sbsl_ram #(
        .DEPTH (MAX_SYMBOLS),
        .WIDTH ($bits(sbsl_sym_t))
    ) u_sym_ram (
        .clk     (clk),
        .wr_en   (sym_we),
        .wr_addr (sym_cnt_reg[SYM_IDX_W-1:0]),
        .wr_data (sym_wr),
        .rd_addr (scan_idx_reg[SYM_IDX_W-1:0]),
        .rd_data (sym_rd)
    );

    always_comb
    begin
        if (state_reg == ST_SPAN)
        begin
            cmp_base     = span_rd.start;
            cmp_limit    = span_rd.length;
            cmp_limit_en = 1'b1;
        end
        else
        begin
            cmp_base     = sym_rd.value;
            cmp_limit    = sym_rd.size;
            cmp_limit_en = sym_rd.size != '0;
        end
    end

    sbsl_cmp_unit u_cmp (
        .probe      (probe_reg),
        .base       (cmp_base),
        .limit      (cmp_limit),
        .limit_en   (cmp_limit_en),
        .best_dist  (best_dist_reg),
        .best_valid (best_valid_reg),
        .res        (cmp)
    );

    assign issue_span = scan_idx_reg < SCAN_W'(span_cnt_reg);
    assign issue_sym  = scan_idx_reg < SCAN_W'(sym_cnt_reg);
    assign sym_cand   = pend_reg && (sym_rd.value != '0) &&
                        (sym_rd.section == SEC_W'(sec_reg)) && cmp.covers && cmp.closer;
    assign name_ok    = {1'b0, best_name_reg} < str_size_reg;
    assign out_free   = !res_valid_reg || result.ready;

    assign request.ready      = state_reg == ST_IDLE;
    assign result.valid       = res_valid_reg;
    assign result.found       = res_found_reg;
    assign result.in_span     = res_in_span_reg;
    assign result.is_code     = res_code_reg;
    assign result.symbol_name = res_name_reg;
    assign result.distance    = res_dist_reg;

    always_comb
    begin
        state_next       = state_reg;
        span_cnt_next    = span_cnt_reg;
        sym_cnt_next     = sym_cnt_reg;
        exec_next        = exec_reg;
        str_size_next    = cfg_we ? cfg_wdata : str_size_reg;
        scan_idx_next    = scan_idx_reg;
        pend_next        = 1'b0;
        span_hit_next    = span_hit_reg;
        best_valid_next  = best_valid_reg;
        res_valid_next   = res_valid_reg && !result.ready;
        probe_next       = probe_reg;
        sec_next         = sec_reg;
        code_next        = code_reg;
        best_dist_next   = best_dist_reg;
        best_name_next   = best_name_reg;
        res_found_next   = res_found_reg;
        res_in_span_next = res_in_span_reg;
        res_code_next    = res_code_reg;
        res_name_next    = res_name_reg;
        res_dist_next    = res_dist_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.kind)
                        KIND_CLEAR:
                        begin
                            span_cnt_next = '0;
                            sym_cnt_next  = '0;
                            exec_next     = '0;
                        end
                        KIND_SPAN:
                        begin
                            if (span_sec_ok && request.is_exec)
                            begin
                                exec_next[request.section[SPAN_SEC_W-1:0]] = 1'b1;
                            end
                            if (span_we)
                            begin
                                span_cnt_next = span_cnt_reg + 1'b1;
                            end
                        end
                        KIND_SYMBOL:
                        begin
                            if (sym_we)
                            begin
                                sym_cnt_next = sym_cnt_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            probe_next      = request.address;
                            scan_idx_next   = '0;
                            span_hit_next   = 1'b0;
                            best_valid_next = 1'b0;
                            state_next      = ST_SPAN;
                        end
                    endcase
                end
            end
            ST_SPAN:
            begin
                if (pend_reg && cmp.covers)
                begin
                    span_hit_next = 1'b1;
                    sec_next      = span_rd.section;
                    code_next     = exec_reg[span_rd.section];
                    scan_idx_next = '0;
                    state_next    = ST_SYM;
                end
                else if (issue_span)
                begin
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SYM:
            begin
                if (sym_cand)
                begin
                    best_valid_next = 1'b1;
                    best_dist_next  = cmp.delta;
                    best_name_next  = sym_rd.name;
                end
                if (issue_sym)
                begin
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next   = 1'b1;
                    res_in_span_next = span_hit_reg;
                    res_code_next    = span_hit_reg && code_reg;
                    res_found_next   = span_hit_reg && best_valid_reg && name_ok;
                    if (span_hit_reg && best_valid_reg && name_ok)
                    begin
                        res_name_next = best_name_reg;
                        res_dist_next = best_dist_reg;
                    end
                    else
                    begin
                        res_name_next = '0;
                        res_dist_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            span_cnt_reg   <= '0;
            sym_cnt_reg    <= '0;
            exec_reg       <= '0;
            str_size_reg   <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            span_hit_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            span_cnt_reg   <= span_cnt_next;
            sym_cnt_reg    <= sym_cnt_next;
            exec_reg       <= exec_next;
            str_size_reg   <= str_size_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            span_hit_reg   <= span_hit_next;
            best_valid_reg <= best_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg       <= probe_next;
        sec_reg         <= sec_next;
        code_reg        <= code_next;
        best_dist_reg   <= best_dist_next;
        best_name_reg   <= best_name_next;
        res_found_reg   <= res_found_next;
        res_in_span_reg <= res_in_span_next;
        res_code_reg    <= res_code_next;
        res_name_reg    <= res_name_next;
        res_dist_reg    <= res_dist_next;
    end

endmodule
